[sv/cikm_pkg.sv]
`default_nettype none

package cikm_pkg;

    // Keyword geometry
    localparam int unsigned KW_CELLS    = 24;
    localparam int unsigned KW_LEN_W    = 5;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_INDEX_W = 3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KW_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KW_LOW    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KW_MID    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KW_HIGH   = 3'd3;

    // ASCII case folding
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_CASE_OFFSET = 8'd32;

    // Per-request control broadcast to every cell
    typedef struct packed {
        logic              en;       // request accepted this cycle
        logic              present;  // request carries a real byte
        logic              clear;    // request closes the record
        logic [CHAR_W-1:0] text;     // folded text byte
    } t_cell_ctl;

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] res;
        res = c;
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            res = c + ASCII_CASE_OFFSET;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/cikm_cell.sv]
`default_nettype none

// One keyword position: holds the flag "keyword prefix up to here ends at the
// latest byte" and hands it to the next position every accepted byte.
module cikm_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire cikm_pkg::t_cell_ctl       i_ctl,
    input  wire logic [cikm_pkg::CHAR_W-1:0] i_key,
    input  wire logic                      i_prev,
    input  wire logic                      i_is_last,
    output logic                           o_match,
    output logic                           o_hit
);

    logic r_match;
    logic n_match;
    logic w_step;

    // Extend the prefix when this byte equals the folded keyword byte
    assign w_step = i_ctl.present && i_prev && (i_ctl.text == cikm_pkg::fold_case(i_key));

    always_comb begin
        n_match = r_match;
        if (i_ctl.en) begin
            if (i_ctl.clear) begin
                n_match = 1'b0;
            end else if (i_ctl.present) begin
                n_match = w_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_match = r_match;
    assign o_hit   = w_step && i_is_last;

endmodule

`default_nettype wire

[sv/case_insensitive_keyword_matcher_unit.sv]
`default_nettype none

// Case-insensitive keyword matcher. Text bytes of a list of records stream in
// on s_axis, one byte per cycle unless stalled; a row of 24 cells, one per
// keyword position, tracks every partial match at once, so a new byte can be
// taken on every clock. One result leaves on m_axis per record end, through
// an output register in the cycle after the closing request is accepted;
// the input stalls only while that output register is full and
// m_axis_tready is low. Program the keyword through the cfg port while the
// stream is idle: index 0 length (0 matches every record, above 24 acts as 24),
// indexes 1..3 keyword bytes 0-7, 8-15, 16-23 with the first byte lowest.
module case_insensitive_keyword_matcher_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [cikm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [cikm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // [7:0] text_char
    input  wire logic [1:0]                          s_axis_tuser,  // [0] char_present, [1] last_of_list
    input  wire logic                                s_axis_tlast,  // last_of_record
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [7:0]                               m_axis_tdata,  // [0] record_matched, [1] any_matched, [7:2] zero
    output logic                                     m_axis_tlast   // list_done
);

    localparam int unsigned N = cikm_pkg::KW_CELLS;

    // Configuration registers
    logic [cikm_pkg::KW_LEN_W-1:0]   r_kw_len;
    logic [cikm_pkg::CFG_DATA_W-1:0] r_kw_low;
    logic [cikm_pkg::CFG_DATA_W-1:0] r_kw_mid;
    logic [cikm_pkg::CFG_DATA_W-1:0] r_kw_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw_len  <= cikm_pkg::KW_LEN_W'(1);
            r_kw_low  <= '0;
            r_kw_mid  <= '0;
            r_kw_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cikm_pkg::REG_KW_LENGTH: r_kw_len  <= i_cfg_data[cikm_pkg::KW_LEN_W-1:0];
                cikm_pkg::REG_KW_LOW:    r_kw_low  <= i_cfg_data;
                cikm_pkg::REG_KW_MID:    r_kw_mid  <= i_cfg_data;
                cikm_pkg::REG_KW_HIGH:   r_kw_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the length to the number of cells
    logic [cikm_pkg::KW_LEN_W-1:0] w_len;
    logic                          w_len_zero;
    logic [3*cikm_pkg::CFG_DATA_W-1:0] w_key_all;

    assign w_len = (r_kw_len > cikm_pkg::KW_LEN_W'(N)) ? cikm_pkg::KW_LEN_W'(N) : r_kw_len;
    assign w_len_zero = (w_len == '0);
    assign w_key_all = {r_kw_high, r_kw_mid, r_kw_low};

    // Accept while the result register is free or being drained
    logic r_out_valid;
    logic w_accept;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    cikm_pkg::t_cell_ctl w_ctl;
    always_comb begin
        w_ctl.en      = w_accept;
        w_ctl.present = s_axis_tuser[0];
        w_ctl.clear   = s_axis_tlast;
        w_ctl.text    = cikm_pkg::fold_case(s_axis_tdata);
    end

    // Row of keyword cells
    logic [N-1:0] w_match;
    logic [N-1:0] w_hit;

    for (genvar j = 0; j < N; j++) begin : g_cell
        logic w_prev;
        logic w_is_last;
        if (j == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_body
            assign w_prev = w_match[j-1];
        end
        assign w_is_last = (w_len == cikm_pkg::KW_LEN_W'(j + 1));

        cikm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_key     (w_key_all[j*cikm_pkg::CHAR_W +: cikm_pkg::CHAR_W]),
            .i_prev    (w_prev),
            .i_is_last (w_is_last),
            .o_match   (w_match[j]),
            .o_hit     (w_hit[j])
        );
    end

    // Record and list flags
    logic r_record_hit;
    logic r_list_hit;
    logic w_hit_now;
    logic w_rec_total;
    logic w_list_total;

    assign w_hit_now    = |w_hit;
    assign w_rec_total  = r_record_hit || w_hit_now || w_len_zero;
    assign w_list_total = r_list_hit || w_rec_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_hit <= 1'b0;
            r_list_hit   <= 1'b0;
        end else if (w_accept) begin
            if (s_axis_tlast) begin
                r_record_hit <= 1'b0;
                r_list_hit   <= s_axis_tuser[1] ? 1'b0 : w_list_total;
            end else if (w_hit_now) begin
                r_record_hit <= 1'b1;
            end
        end
    end

    // Result register
    logic r_out_rec;
    logic r_out_any;
    logic r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && s_axis_tlast) begin
            r_out_rec  <= w_rec_total;
            r_out_any  <= w_list_total;
            r_out_last <= s_axis_tuser[1];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_any, r_out_rec};
    assign m_axis_tlast  = r_out_last;

    // Checks
    a_rec_implies_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[0] || m_axis_tdata[1]))
        else $error("record match without list match");

    a_cells_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tlast) |=> (w_match == '0))
        else $error("cell flags not cleared at record end");

    a_list_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tlast && s_axis_tuser[1]) |=> (!r_list_hit && !r_record_hit))
        else $error("list flag not cleared at list end");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_accept)
        else $error("request accepted over a waiting result");

endmodule

`default_nettype wire

[bench/case_insensitive_keyword_matcher_unit_test.sv]
`timescale 1ns / 100ps

// One record verdict as it leaves the result stream
typedef struct packed {
    logic matched;
    logic so_far;
    logic done;
} t_match_result;

// Keyword search predictor and store of pending record verdicts
class match_scoreboard;
    logic [4:0]         len_reg;
    logic [7:0]         key_raw [cikm_pkg::KW_CELLS];
    logic [7:0]         history [cikm_pkg::KW_CELLS];
    int unsigned        seen_chars;
    bit                 record_hit;
    bit                 list_hit;
    t_match_result      verdict_q [$];
    int unsigned        errors;
    int unsigned        checked;
    int unsigned        hits;
    int unsigned        lists;

    function new();
        len_reg = 5'd1;
        foreach (key_raw[i]) key_raw[i] = 8'h00;
        clear_record();
        list_hit = 1'b0;
        errors   = 0;
        checked  = 0;
        hits     = 0;
        lists    = 0;
    endfunction

    static function logic [7:0] lower_case(input logic [7:0] c);
        if (c >= cikm_pkg::ASCII_UPPER_A && c <= cikm_pkg::ASCII_UPPER_Z) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function void clear_record();
        foreach (history[i]) history[i] = 8'h00;
        seen_chars = 0;
        record_hit = 1'b0;
    endfunction

    function int unsigned usable_len();
        return (len_reg > cikm_pkg::KW_CELLS) ? cikm_pkg::KW_CELLS : len_reg;
    endfunction

    function int pending();
        return verdict_q.size();
    endfunction

    // Mirror a register write; unknown indexes are dropped
    function void write_reg(input logic [cikm_pkg::CFG_INDEX_W-1:0] idx,
                            input logic [cikm_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            cikm_pkg::REG_KW_LENGTH: len_reg = data[4:0];
            cikm_pkg::REG_KW_LOW: begin
                for (int i = 0; i < 8; i++) key_raw[i] = data[8*i +: 8];
            end
            cikm_pkg::REG_KW_MID: begin
                for (int i = 0; i < 8; i++) key_raw[8 + i] = data[8*i +: 8];
            end
            cikm_pkg::REG_KW_HIGH: begin
                for (int i = 0; i < 8; i++) key_raw[16 + i] = data[8*i +: 8];
            end
            default: ;
        endcase
    endfunction

    // Advance the search by one accepted request, queue a verdict on record end
    function void note_request(input logic [7:0] ch, input logic present,
                               input logic rec_end, input logic list_end);
        logic [7:0]    c;
        logic [7:0]    t;
        int unsigned   len;
        bit            hit;
        t_match_result r;
        c   = lower_case(ch);
        len = usable_len();
        if (present) begin
            if (seen_chars < cikm_pkg::KW_CELLS) seen_chars++;
            hit = (seen_chars >= len);
            // compare the window ending at the current byte, newest first
            for (int k = 0; k < len; k++) begin
                t = (k == 0) ? c : history[k - 1];
                if (t != lower_case(key_raw[len - 1 - k])) hit = 1'b0;
            end
            if (hit) record_hit = 1'b1;
            for (int k = cikm_pkg::KW_CELLS - 1; k > 0; k--) history[k] = history[k - 1];
            history[0] = c;
        end
        if (rec_end) begin
            if (len == 0) record_hit = 1'b1;
            if (record_hit) list_hit = 1'b1;
            r.matched = record_hit;
            r.so_far  = list_hit;
            r.done    = list_end;
            verdict_q.push_back(r);
            clear_record();
            if (list_end) list_hit = 1'b0;
        end
    endfunction

    // Compare one result with the oldest pending verdict
    function void check_result(input logic [7:0] data, input logic last);
        t_match_result want;
        if (verdict_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing pending, expected none, actual tdata=%h tlast=%b",
                     $time, data, last);
            return;
        end
        want = verdict_q.pop_front();
        checked++;
        if (want.matched) hits++;
        if (want.done) lists++;
        if (data[0] !== want.matched) begin
            errors++;
            $display("%0t: record_matched expected %b actual %b", $time, want.matched, data[0]);
        end
        if (data[1] !== want.so_far) begin
            errors++;
            $display("%0t: any_matched expected %b actual %b", $time, want.so_far, data[1]);
        end
        if (last !== want.done) begin
            errors++;
            $display("%0t: list_done expected %b actual %b", $time, want.done, last);
        end
        if (data[7:2] !== 6'd0) begin
            errors++;
            $display("%0t: tdata padding expected 00 actual %h", $time, data[7:2]);
        end
    endfunction
endclass

module case_insensitive_keyword_matcher_unit_test;

    localparam int unsigned IDLE_LIMIT   = 1000;
    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned PHASE_ITEMS  = 36;

    typedef enum logic [1:0] {RX_ALWAYS, RX_MOSTLY, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [cikm_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [cikm_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata = '0;
    logic [1:0]                       s_axis_tuser = '0;
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [7:0]                       m_axis_tdata;
    logic                             m_axis_tlast;

    match_scoreboard        sb;
    logic [7:0]             kw_text [cikm_pkg::KW_CELLS];
    int unsigned            kw_used = 1;
    int unsigned            burst_left = 0;
    int unsigned            sent_items = 0;
    int unsigned            settings = 0;
    int unsigned            idle_cycles = 0;
    logic [15:0]            rx_cycle = '0;
    t_rx_mode               rx_mode = RX_ALWAYS;
    logic [4:0]             len_plan [7] = '{5'd24, 5'd31, 5'd1, 5'd2, 5'd25, 5'd3, 5'd0};

    case_insensitive_keyword_matcher_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result side: pick a new pattern each time rx_cycle[5:0] is zero
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 16'd1;
        if (rx_cycle[5:0] == 6'd0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_ALWAYS:   m_axis_tready <= 1'b1;
            RX_MOSTLY:   m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_axis_tready <= (rx_cycle[2:0] == 3'd0);
            default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Check results and watch for a hung block
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tlast);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Send one request, idling between bursts
    task automatic send_request(input logic [7:0] ch, input logic present,
                                input logic rec_end, input logic list_end);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= {list_end, present};
        s_axis_tlast  <= rec_end;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(ch, present, rec_end, list_end);
        burst_left--;
        if (present || rec_end) sent_items++;
    endtask

    // Drop valid, wait for every verdict, then let trailing bytes settle
    task automatic drain_stream();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_register(input logic [cikm_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [cikm_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Load kw_text with the given length code, plus one write to an unused index
    task automatic program_keyword(input logic [4:0] len_code);
        logic [cikm_pkg::CFG_DATA_W-1:0] word [3];
        for (int w = 0; w < 3; w++) begin
            for (int i = 0; i < 8; i++) word[w][8*i +: 8] = kw_text[8*w + i];
        end
        put_register(cikm_pkg::REG_KW_LENGTH, {$urandom, 27'($urandom), len_code});
        put_register(cikm_pkg::REG_KW_LOW, word[0]);
        put_register(cikm_pkg::REG_KW_MID, word[1]);
        put_register(cikm_pkg::REG_KW_HIGH, word[2]);
        put_register(cikm_pkg::CFG_INDEX_W'($urandom_range(int'(cikm_pkg::REG_KW_HIGH) + 1,
                                                           (1 << cikm_pkg::CFG_INDEX_W) - 1)),
                     {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        kw_used = (len_code > cikm_pkg::KW_CELLS) ? cikm_pkg::KW_CELLS : len_code;
        settings++;
    endtask

    // Letters near the fold boundaries, zero, all ones, or anything
    function automatic logic [7:0] alphabet_char();
        case ($urandom_range(0, 9))
            0: return "a";
            1: return "A";
            2: return "b";
            3: return "B";
            4: return "z";
            5: return "Z";
            6: begin
                case ($urandom_range(0, 3))
                    0: return 8'h40;
                    1: return 8'h5B;
                    2: return 8'h60;
                    default: return 8'h7B;
                endcase
            end
            7: return 8'h00;
            8: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1) == 1) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // Filler leaning on keyword bytes so partial matches happen often
    function automatic logic [7:0] text_char();
        if (kw_used != 0 && $urandom_range(0, 1) == 1) begin
            return flip_case(kw_text[$urandom_range(0, kw_used - 1)]);
        end
        return alphabet_char();
    endfunction

    // Send one record: filler around the keyword, a spoiled keyword, filler only, or an empty record
    task automatic send_record(input logic close_list);
        logic [7:0]  body [$];
        int unsigned kind;
        bit          marker_end;
        bit          trailing;
        kind = $urandom_range(0, 11);
        if (kind == 0) begin
            send_request(8'($urandom), 1'b0, 1'b1, close_list);
            return;
        end
        repeat ($urandom_range(0, 6)) body.push_back(text_char());
        if (kind <= 8 && kw_used != 0) begin
            for (int i = 0; i < kw_used; i++) body.push_back(flip_case(kw_text[i]));
            if (kind == 7) begin
                body[body.size() - 1 - $urandom_range(0, kw_used - 1)] ^= 8'h01;
            end
            if (kind == 8) void'(body.pop_back());
        end
        repeat ($urandom_range(0, 6)) body.push_back(text_char());
        marker_end = (body.size() == 0) || ($urandom_range(0, 4) == 0);
        for (int i = 0; i < body.size(); i++) begin
            // stray empty items and list flags away from a record end
            if ($urandom_range(0, 11) == 0) begin
                send_request(8'($urandom), 1'b0, 1'b0, 1'($urandom));
            end
            trailing = (i == body.size() - 1) && !marker_end;
            send_request(body[i], 1'b1, trailing,
                         trailing ? close_list : ($urandom_range(0, 7) == 0));
        end
        if (marker_end) send_request(8'($urandom), 1'b0, 1'b1, close_list);
    endtask

    initial begin
        logic [4:0]  len_code;
        int unsigned phase;
        int unsigned phase_start;
        int unsigned random_start;
        sb = new();
        foreach (kw_text[i]) kw_text[i] = 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset keyword is a single zero byte
        send_request("Q", 1'b1, 1'b1, 1'b0);
        send_request(8'h00, 1'b1, 1'b1, 1'b1);
        drain_stream();

        // mixed-case keyword, folding in both directions
        foreach (kw_text[i]) kw_text[i] = 8'($urandom);
        kw_text[0] = "A";
        kw_text[1] = "b";
        kw_text[2] = "Z";
        program_keyword(5'd3);
        send_request("x", 1'b1, 1'b0, 1'b0);
        send_request("a", 1'b1, 1'b0, 1'b0);
        send_request("B", 1'b1, 1'b0, 1'b0);
        send_request("z", 1'b1, 1'b1, 1'b0);
        // keyword split over two records must not match
        send_request("a", 1'b1, 1'b0, 1'b0);
        send_request("b", 1'b1, 1'b1, 1'b0);
        send_request("z", 1'b1, 1'b0, 1'b0);
        send_request("q", 1'b1, 1'b1, 1'b0);
        // empty record, then an item that carries nothing
        send_request(8'h00, 1'b0, 1'b1, 1'b0);
        send_request(8'hA5, 1'b0, 1'b0, 1'b0);
        // zero byte with a list flag but no record end
        send_request(8'h00, 1'b1, 1'b0, 1'b1);
        send_request(8'h40, 1'b1, 1'b0, 1'b0);
        send_request(8'h5B, 1'b1, 1'b0, 1'b0);
        send_request(8'h60, 1'b1, 1'b0, 1'b0);
        send_request(8'h7B, 1'b1, 1'b0, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0, 1'b0);
        send_request(8'h5A, 1'b0, 1'b1, 1'b1);
        drain_stream();

        // empty keyword matches every record, the empty one too
        foreach (kw_text[i]) kw_text[i] = 8'hFF;
        program_keyword(5'd0);
        send_request(8'h00, 1'b0, 1'b1, 1'b1);
        send_request("q", 1'b1, 1'b1, 1'b1);
        drain_stream();

        // random phases, each with its own keyword setting
        phase = 0;
        random_start = sent_items;
        while (sent_items - random_start < RANDOM_ITEMS) begin
            if (phase < 7) begin
                len_code = len_plan[phase];
            end else if ($urandom_range(0, 3) == 0) begin
                len_code = 5'($urandom_range(0, 31));
            end else begin
                len_code = 5'($urandom_range(1, 8));
            end
            foreach (kw_text[i]) kw_text[i] = alphabet_char();
            program_keyword(len_code);
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS) send_record($urandom_range(0, 3) == 0);
            send_record(1'b1);
            drain_stream();
            phase++;
        end

        $display("Checked %0d record verdicts (%0d hits, %0d list ends) over %0d requests",
                 sb.checked, sb.hits, sb.lists, sent_items);
        $display("Keyword settings applied: %0d, lengths from empty through clamped",
                 settings);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
